@@ sv/mh32_pkg.sv @@
// Package for the streaming 32-bit MurmurHash2 block.
// Holds the mixing constants and the request type of the shared multiplier.
// No dependencies.
package mh32_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned LenW  = 31;

  localparam logic [HashW-1:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned      MixShift  = 24;
  localparam int unsigned      FinShiftA = 13;
  localparam int unsigned      FinShiftB = 15;
  localparam logic [LenW-1:0]  CountMax  = 31'h7fffffff;

  // One request to the shared multiplier: enable and operand.
  typedef struct packed {
    logic             en;
    logic [HashW-1:0] a;
  } mh32_op_t;

endpackage

@@ sv/mh32_mult.sv @@
// Shared multiplier of the MurmurHash2 block: registered product of the
// operand and the mixing constant, modulo 2^32. Depends on mh32_pkg.
module mh32_mult (
  input  logic                           clk_i,
  input  mh32_pkg::mh32_op_t             op_i,
  output logic [mh32_pkg::HashW-1:0]     prod_o
);
  import mh32_pkg::*;

  logic [HashW-1:0] prod_q;

  // The product holds while no request is issued, so the sequencer may
  // read it in any later step.
  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_q <= op_i.a * MixMul;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ sv/murmur_hash_32.sv @@
// Streaming 32-bit MurmurHash2, one byte per input transaction (mh32_pkg, mh32_mult).
// A byte that does not complete a word is absorbed in the idle state; a byte that
// completes a word runs K1, K2, H1 and HX (three products through the one multiplier).
// A last transaction then runs TAIL, TW when tail bytes are pending, F1 and F2; F2 waits
// while the output register stays stalled, and its exit loads the result. New bytes stall
// until idle. Reset (rst_ni low, async) clears all state but k, hash and error.
module murmur_hash_32 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel (seed)
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mh32_pkg::HashW-1:0]    cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic [mh32_pkg::LenW-1:0]     message_length_i,
  input  logic                          first_i,
  input  logic                          last_i,
  input  logic                          has_data_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mh32_pkg::HashW-1:0]    hash_o,
  output logic                          length_error_o
);
  import mh32_pkg::*;

  // Sequencer states. Each multiplier step issues an operand in one state
  // and the product is read in the state that follows.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,  // accept a byte, update lane and count
    S_K1   = 9'b000000010,  // k * M
    S_K2   = 9'b000000100,  // (k ^ k >> 24) * M
    S_H1   = 9'b000001000,  // h * M, keep mixed k
    S_HX   = 9'b000010000,  // h = h * M ^ k
    S_TAIL = 9'b000100000,  // (h ^ tail bytes) * M when bytes are pending
    S_TW   = 9'b001000000,  // take the tail product
    S_F1   = 9'b010000000,  // (h ^ h >> 13) * M
    S_F2   = 9'b100000000   // final shift, load output register
  } state_e;

  state_e           state_q, state_d;
  logic [HashW-1:0] seed_q;
  logic [HashW-1:0] h_q, h_d;
  logic [23:0]      pw_q, pw_d;
  logic [1:0]       lane_q, lane_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  decl_q, decl_d;
  logic             last_q;
  logic [HashW-1:0] k_q, k_d;
  logic             out_valid_q;
  logic [HashW-1:0] hash_q;
  logic             err_q;

  logic             in_acc;
  logic             out_free;
  logic [HashW-1:0] prod;
  mh32_op_t         op;

  // Per-message values after the first flag has been applied.
  logic [HashW-1:0] h_b;
  logic [23:0]      pw_b;
  logic [1:0]       lane_b;
  logic [LenW-1:0]  cnt_b;
  logic [LenW-1:0]  decl_b;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  // The output register can take a new result when it is empty or its
  // current transaction completes in this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (first_i) begin
      h_b    = seed_q ^ {1'b0, message_length_i};
      pw_b   = '0;
      lane_b = '0;
      cnt_b  = '0;
      decl_b = message_length_i;
    end else begin
      h_b    = h_q;
      pw_b   = pw_q;
      lane_b = lane_q;
      cnt_b  = cnt_q;
      decl_b = decl_q;
    end
  end

  // Absorb one byte. The fourth byte of a word goes to k for mixing and
  // the pending word is cleared.
  always_comb begin
    h_d    = h_b;
    pw_d   = pw_b;
    lane_d = lane_b;
    cnt_d  = cnt_b;
    decl_d = decl_b;
    k_d    = {data_byte_i, pw_b};
    if (has_data_i) begin
      if (cnt_b != CountMax) begin
        cnt_d = cnt_b + 1'b1;
      end
      case (lane_b)
        2'd0: begin
          pw_d[7:0] = data_byte_i;
          lane_d    = 2'd1;
        end
        2'd1: begin
          pw_d[15:8] = data_byte_i;
          lane_d     = 2'd2;
        end
        2'd2: begin
          pw_d[23:16] = data_byte_i;
          lane_d      = 2'd3;
        end
        default: begin
          pw_d   = '0;
          lane_d = 2'd0;
        end
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op.en = 1'b0;
    op.a  = h_q;
    case (state_q)
      S_K1: begin
        op.en = 1'b1;
        op.a  = k_q;
      end
      S_K2: begin
        op.en = 1'b1;
        op.a  = prod ^ (prod >> MixShift);
      end
      S_H1: begin
        op.en = 1'b1;
        op.a  = h_q;
      end
      S_TAIL: begin
        op.en = (lane_q != 2'd0);
        op.a  = h_q ^ {8'd0, pw_q};
      end
      S_F1: begin
        op.en = 1'b1;
        op.a  = h_q ^ (h_q >> FinShiftA);
      end
      default: begin
        op.en = 1'b0;
        op.a  = h_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (has_data_i && (lane_b == 2'd3)) begin
            state_d = S_K1;
          end else if (last_i) begin
            state_d = S_TAIL;
          end
        end
      end
      S_K1:   state_d = S_K2;
      S_K2:   state_d = S_H1;
      S_H1:   state_d = S_HX;
      S_HX:   state_d = last_q ? S_TAIL : S_IDLE;
      S_TAIL: state_d = (lane_q != 2'd0) ? S_TW : S_F1;
      S_TW:   state_d = S_F1;
      S_F1:   state_d = S_F2;
      S_F2: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  mh32_mult u_mult (
    .clk_i  (clk_i),
    .op_i   (op),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= '0;
      h_q         <= '0;
      pw_q        <= '0;
      lane_q      <= '0;
      cnt_q       <= '0;
      decl_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_data_i;
      end
      if ((state_q == S_F2) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            h_q    <= h_d;
            pw_q   <= pw_d;
            lane_q <= lane_d;
            cnt_q  <= cnt_d;
            decl_q <= decl_d;
            last_q <= last_i;
          end
        end
        S_HX: h_q <= prod ^ k_q;
        S_TW: h_q <= prod;
        S_F2: begin
          if (out_free) begin
            h_q         <= '0;
            pw_q        <= '0;
            lane_q      <= '0;
            cnt_q       <= '0;
            decl_q      <= '0;
            last_q      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: mixed word and the result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q <= k_d;
    end else if (state_q == S_H1) begin
      k_q <= prod;
    end
    if ((state_q == S_F2) && out_free) begin
      hash_q <= prod ^ (prod >> FinShiftB);
      err_q  <= (cnt_q != decl_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hash_o         = hash_q;
  assign length_error_o = err_q;

  // A byte that completes a word always starts the word mix.
  a_word_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && has_data_i && !first_i && (lane_q == 2'd3)) |=> (state_q == S_K1))
    else $error("completed word did not start the mix sequence");

  // Finishing a message shows a result and leaves a clean message state.
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_F2) && out_free) |=>
      (out_valid_o && (lane_q == 2'd0) && (cnt_q == '0) && (h_q == '0)))
    else $error("message end did not produce a result or clear state");

  // Lane and count only move on an accepted byte or at message end.
  a_lane_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && (state_q != S_F2)) |=> ($stable(lane_q) && $stable(cnt_q)))
    else $error("byte lane or count changed while busy");

  // The sequencer is always in exactly one state.
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

endmodule

@@ tb/sv/tb_murmur_hash_32.sv @@
// Self-checking testbench for murmur_hash_32, the streaming 32-bit MurmurHash2 block.
// Uses the mh32_pkg constants and port widths. It needs nothing but the RTL.
`timescale 1ns / 100ps

module tb_murmur_hash_32;
  import mh32_pkg::*;

  // One input transaction as the driver presents it.
  typedef struct {
    logic [7:0]      data;
    logic [LenW-1:0] msg_len;
    logic            is_first;
    logic            is_last;
    logic            has_data;
  } hash_item_t;

  // One result transaction as the monitor expects to see it.
  typedef struct {
    logic [HashW-1:0] hash;
    logic             len_err;
  } hash_result_t;

  // This is the watchdog limit. It leaves a wide margin over the slowest correct run.
  localparam int unsigned CycleLimit = 150000;
  // This is the hold on the result side that fills the block and backs up its input.
  localparam int unsigned LongHold   = 300;
  // These are the extra cycles after the last result before a seed write or the end.
  localparam int unsigned SettleCycles = 12;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [HashW-1:0]      cfg_data_i       = '0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i      = '0;
  logic [LenW-1:0]       message_length_i = '0;
  logic                  first_i          = 1'b0;
  logic                  last_i           = 1'b0;
  logic                  has_data_i       = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i      = 1'b0;
  logic [HashW-1:0]      hash_o;
  logic                  length_error_o;

  murmur_hash_32 dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .first_i          (first_i),
    .last_i           (last_i),
    .has_data_i       (has_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_o           (hash_o),
    .length_error_o   (length_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The byte items wait here until the driver picks them up.
  hash_item_t   byte_items_q[$];
  // The hashes still to come, oldest first.
  hash_result_t hash_expect_q[$];

  int unsigned items_queued = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  bit          no_idle      = 1'b0;
  bit          hold_arm     = 1'b0;

  // This is the predictor's copy of the seed register and the message state.
  logic [HashW-1:0] seed_q    = '0;
  logic [HashW-1:0] run_hash  = '0;
  logic [23:0]      part_word = '0;
  logic [1:0]       lane      = '0;
  logic [LenW-1:0]  rx_count  = '0;
  logic [LenW-1:0]  decl_len  = '0;

  // The predictor advances the hash by one accepted input transaction. The order is the
  // first flag (restart), then the byte (pack or fold a word), then the last flag
  // (tail, avalanche, emit). A message that ends brings the state back to zero.
  task automatic murmur_absorb(input hash_item_t it);
    logic [HashW-1:0] k;
    logic [HashW-1:0] h;
    hash_result_t     res;
    if (it.is_first) begin
      run_hash  = seed_q ^ {1'b0, it.msg_len};
      decl_len  = it.msg_len;
      part_word = '0;
      lane      = '0;
      rx_count  = '0;
    end
    if (it.has_data) begin
      // The count saturates. Word grouping always follows the real bytes.
      if (rx_count != CountMax) rx_count = rx_count + 1'b1;
      if (lane == 2'd3) begin
        k = {it.data, part_word};
        k = k * MixMul;
        k = k ^ (k >> MixShift);
        k = k * MixMul;
        run_hash  = (run_hash * MixMul) ^ k;
        part_word = '0;
        lane      = '0;
      end else begin
        part_word[8*lane +: 8] = it.data;
        lane = lane + 1'b1;
      end
    end
    if (it.is_last) begin
      h = run_hash;
      if (lane != 2'd0) begin
        h = h ^ {8'h00, part_word};
        h = h * MixMul;
      end
      h = h ^ (h >> FinShiftA);
      h = h * MixMul;
      h = h ^ (h >> FinShiftB);
      res.hash    = h;
      res.len_err = (rx_count != decl_len);
      hash_expect_q.push_back(res);
      run_hash  = '0;
      part_word = '0;
      lane      = '0;
      rx_count  = '0;
      decl_len  = '0;
    end
  endtask

  // The driver holds one transaction on the input until the block takes it. The
  // prediction is made at that edge. Then it waits a random gap and loads the next
  // transaction. With a zero gap, valid simply stays high.
  hash_item_t  cur_item;
  int unsigned drv_wait = 0;
  logic        offer;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        murmur_absorb(cur_item);
        offer    = 1'b0;
        drv_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (!offer) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (byte_items_q.size() != 0) begin
          cur_item         = byte_items_q.pop_front();
          offer            = 1'b1;
          data_byte_i      <= cur_item.data;
          message_length_i <= cur_item.msg_len;
          first_i          <= cur_item.is_first;
          last_i           <= cur_item.is_last;
          has_data_i       <= cur_item.has_data;
        end
      end
      in_valid_i <= offer;
    end
  end

  // The monitor compares each accepted result with the oldest expectation. After each
  // result it draws how many cycles the next result has to wait. That wait only counts
  // down while a result is actually offered, so the stall really hits the output. One
  // long hold, counted here, backs the block up into its input.
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  hash_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (hash_expect_q.size() == 0) begin
          $display("%0t: result with none expected, actual hash %h length_error %b",
                   $time, hash_o, length_error_o);
          err_count++;
        end else begin
          want = hash_expect_q.pop_front();
          if (hash_o !== want.hash) begin
            $display("%0t: hash mismatch, expected %h, actual %h",
                     $time, want.hash, hash_o);
            err_count++;
          end
          if (length_error_o !== want.len_err) begin
            $display("%0t: length_error mismatch, expected %b, actual %b",
                     $time, want.len_err, length_error_o);
            err_count++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_arm && !hold_used) begin
        hold_left = LongHold;
        hold_used = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  // This is the watchdog. A hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] data, input logic [LenW-1:0] msg_len,
                           input logic is_first, input logic is_last,
                           input logic has_data);
    hash_item_t it;
    it.data     = data;
    it.msg_len  = msg_len;
    it.is_first = is_first;
    it.is_last  = is_last;
    it.has_data = has_data;
    byte_items_q.push_back(it);
    items_queued++;
  endtask

  // This queues one message of nbytes random bytes. The declared length is usually
  // right and sometimes off by one or fully random. Now and then a transaction without
  // data sits in the middle. With cut_short set, the message never ends, so the next
  // first flag restarts it.
  task automatic queue_message(input int nbytes, input bit cut_short);
    int unsigned     pick;
    logic [LenW-1:0] declared;
    pick = $urandom_range(0, 99);
    if (pick < 80)      declared = LenW'(nbytes);
    else if (pick < 90) declared = LenW'($urandom);
    else if (pick < 95) declared = LenW'(nbytes + 1);
    else                declared = LenW'(nbytes - 1);
    if (nbytes == 0) begin
      push_item(8'($urandom), declared, 1'b1, !cut_short, 1'b0);
    end else begin
      for (int i = 0; i < nbytes; i++) begin
        if (i > 0 && $urandom_range(0, 19) == 0)
          push_item(8'($urandom), LenW'($urandom), 1'b0, 1'b0, 1'b0);
        push_item(8'($urandom), (i == 0) ? declared : LenW'($urandom), i == 0,
                  (i == nbytes - 1) && !cut_short, 1'b1);
      end
    end
  endtask

  // This queues about n_items transactions. Most are whole messages and a few are cut
  // short. Some loose transactions without a first flag continue from whatever state
  // is left. The phase always ends with a whole message, so the block goes idle.
  task automatic queue_random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int          nb;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      nb   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      if (pick < 8)
        queue_message(nb, 1'b1);
      else if (pick < 12)
        push_item(8'($urandom), LenW'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        queue_message(nb, 1'b0);
    end
    queue_message($urandom_range(0, 12), 1'b0);
  endtask

  // This waits until every transaction has gone in and every hash has come out, then
  // lets the block's own latency pass.
  task automatic wait_idle();
    while (byte_items_q.size() != 0 || in_valid_i || hash_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [HashW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    seed_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  logic [HashW-1:0] phase_seeds[5];

  initial begin
    phase_seeds[0] = 32'hffffffff;
    phase_seeds[1] = 32'h00000000;
    phase_seeds[2] = $urandom;
    phase_seeds[3] = 32'h80000001;
    phase_seeds[4] = $urandom;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed part runs with the seed at its reset value.
    // These are loose bytes straight after reset, with no first flag. They hash from
    // the zero state with a declared length of zero.
    push_item(8'hff, 31'h7fffffff, 1'b0, 1'b0, 1'b1);
    push_item(8'h00, 31'h0,        1'b0, 1'b1, 1'b1);
    // These are empty messages, with the length right and with the length at its maximum.
    push_item(8'h5a, 31'h0,        1'b1, 1'b1, 1'b0);
    push_item(8'ha5, 31'h7fffffff, 1'b1, 1'b1, 1'b0);
    // This is a single byte message, so the tail holds one byte.
    push_item(8'hab, 31'd1,        1'b1, 1'b1, 1'b1);
    // This is one full word with the byte extremes in it.
    push_item(8'h00, 31'd4,        1'b1, 1'b0, 1'b1);
    push_item(8'hff, 31'h0,        1'b0, 1'b0, 1'b1);
    push_item(8'h80, 31'h7fffffff, 1'b0, 1'b0, 1'b1);
    push_item(8'h7f, 31'h0,        1'b0, 1'b1, 1'b1);
    // A first flag inside an open message drops the pending bytes and starts again.
    push_item(8'h11, 31'd3,        1'b1, 1'b0, 1'b1);
    push_item(8'h22, 31'd3,        1'b0, 1'b0, 1'b1);
    push_item(8'h33, 31'd2,        1'b1, 1'b0, 1'b1);
    push_item(8'h44, 31'd2,        1'b0, 1'b1, 1'b1);
    // A transaction without data in the middle of a message absorbs nothing.
    push_item(8'h01, 31'd3,        1'b1, 1'b0, 1'b1);
    push_item(8'hee, 31'h2aaaaaaa, 1'b0, 1'b0, 1'b0);
    push_item(8'h02, 31'd3,        1'b0, 1'b0, 1'b1);
    push_item(8'h03, 31'd3,        1'b0, 1'b1, 1'b1);
    // The message ends on a transaction that carries no byte. The tail has two bytes.
    push_item(8'hc3, 31'd2,        1'b1, 1'b0, 1'b1);
    push_item(8'h3c, 31'd2,        1'b0, 1'b0, 1'b1);
    push_item(8'hff, 31'h55555555, 1'b0, 1'b1, 1'b0);
    // This is a seven byte message, so a full word and then a three byte tail.
    for (int i = 0; i < 7; i++)
      push_item(8'(8'h90 + i), 31'd7, i == 0, i == 6, 1'b1);
    wait_idle();

    // In the random phases each one runs under a new seed. Phase 1 carries the long
    // hold on the result side, and phase 2 runs with no idling on either side.
    for (int p = 0; p < 5; p++) begin
      write_seed(phase_seeds[p]);
      no_idle = (p == 2);
      queue_random_phase(160);
      if (p == 1) hold_arm = 1'b1;
      wait_idle();
    end

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
